// ===== rtl/shdl_pkg.sv =====
// Package for the sync/header/length deframer.
// Holds the frame constants, register indexes and the per-byte result struct.
// No dependencies.
package shdl_pkg;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned SIZE_W    = 32;

  // Frame layout
  localparam logic [BYTE_W-1:0]  SYNC_BYTE   = 8'h4E;
  localparam logic [COUNT_W-1:0] CONFIRM_LEN = 32'd5;
  localparam logic [COUNT_W-1:0] SIZE_LEN    = 32'd4;
  localparam logic [COUNT_W-1:0] CRC_LEN     = 32'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRE_SKIP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POST_SKIP = 1'd1;

  // Expected confirmation string, one byte per position
  function automatic logic [BYTE_W-1:0] confirm_byte(input logic [2:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      3'd0:    b = 8'h41;
      3'd1:    b = 8'h49;
      3'd2:    b = 8'h4F;
      3'd3:    b = 8'h30;
      3'd4:    b = 8'h31;
      default: b = 8'h31;
    endcase
    return b;
  endfunction

  // Result of one received byte
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic              payload_last;
    logic              frame_done;
    logic              sync_error;
  } shdl_result_t;

endpackage

// ===== rtl/shdl_fsm.sv =====
// Frame phase tracker: holds phase, byte count, block size and confirm flag.
// Produces the result of the byte stepped in this cycle.
// Depends on shdl_pkg.
module shdl_fsm (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [shdl_pkg::BYTE_W-1:0]    rx_byte,
  input  logic [shdl_pkg::CFG_W-1:0]     pre_skip,
  input  logic [shdl_pkg::CFG_W-1:0]     post_skip,
  output shdl_pkg::shdl_result_t         result
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CONFIRM,
    PH_ID,
    PH_SIZE,
    PH_PRE,
    PH_DATA,
    PH_POST,
    PH_CRC
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  logic [shdl_pkg::COUNT_W-1:0]     cnt_r, cnt_nxt;
  logic [shdl_pkg::SIZE_W-1:0]      bs_r, bs_nxt;
  logic                             ok_r, ok_nxt;

  logic [shdl_pkg::COUNT_W:0]       cnt_inc;
  logic [shdl_pkg::CFG_W:0]         skip_sum;
  logic [shdl_pkg::COUNT_W+1:0]     data_end;
  logic                             pre_zero, post_zero, len_zero;
  logic                             ok_byte;

  // Skip through empty phases on entry
  function automatic phase_t enter_ph(input phase_t p, input logic pz,
                                      input logic lz, input logic qz);
    phase_t q;
    q = p;
    if (q == PH_PRE && pz) q = PH_DATA;
    if (q == PH_DATA && lz) q = PH_POST;
    if (q == PH_POST && qz) q = PH_CRC;
    return q;
  endfunction

  assign cnt_inc   = {1'b0, cnt_r} + 33'd1;
  assign skip_sum  = {1'b0, pre_skip} + {1'b0, post_skip};
  assign data_end  = {1'b0, cnt_inc} + {17'd0, skip_sum};
  assign pre_zero  = (pre_skip == '0);
  assign post_zero = (post_skip == '0);
  assign ok_byte   = (rx_byte == shdl_pkg::confirm_byte(cnt_r[2:0]));
  // Payload is empty when block size does not exceed the sum of both skips
  assign len_zero  = ({1'b0, bs_nxt} <= {16'd0, skip_sum});

  // Next state and result for the byte at the input
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bs_nxt    = bs_r;
    ok_nxt    = ok_r;
    result    = '0;
    case (phase_r)
      PH_CONFIRM: begin
        cnt_nxt = cnt_inc[shdl_pkg::COUNT_W-1:0];
        if (cnt_inc >= {1'b0, shdl_pkg::CONFIRM_LEN}) begin
          cnt_nxt = '0;
          ok_nxt  = 1'b1;
          if (ok_r && ok_byte) begin
            phase_nxt = PH_ID;
          end else begin
            phase_nxt         = PH_HUNT;
            result.sync_error = 1'b1;
          end
        end else begin
          ok_nxt = ok_r & ok_byte;
        end
      end
      PH_ID: begin
        phase_nxt = PH_SIZE;
        cnt_nxt   = '0;
        bs_nxt    = '0;
      end
      PH_SIZE: begin
        bs_nxt  = {bs_r[shdl_pkg::SIZE_W-9:0], rx_byte};
        cnt_nxt = cnt_inc[shdl_pkg::COUNT_W-1:0];
        if (cnt_inc >= {1'b0, shdl_pkg::SIZE_LEN}) begin
          cnt_nxt   = '0;
          phase_nxt = enter_ph(PH_PRE, pre_zero, len_zero, post_zero);
        end
      end
      PH_PRE: begin
        cnt_nxt = cnt_inc[shdl_pkg::COUNT_W-1:0];
        if (cnt_inc >= {17'd0, pre_skip}) begin
          cnt_nxt   = '0;
          phase_nxt = enter_ph(PH_DATA, pre_zero, len_zero, post_zero);
        end
      end
      PH_DATA: begin
        result.payload_byte  = rx_byte;
        result.payload_valid = 1'b1;
        cnt_nxt              = cnt_inc[shdl_pkg::COUNT_W-1:0];
        if (data_end >= {2'b0, bs_r}) begin
          result.payload_last = 1'b1;
          cnt_nxt             = '0;
          phase_nxt           = enter_ph(PH_POST, pre_zero, len_zero, post_zero);
        end
      end
      PH_POST: begin
        cnt_nxt = cnt_inc[shdl_pkg::COUNT_W-1:0];
        if (cnt_inc >= {17'd0, post_skip}) begin
          cnt_nxt   = '0;
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        cnt_nxt = cnt_inc[shdl_pkg::COUNT_W-1:0];
        if (cnt_inc >= {1'b0, shdl_pkg::CRC_LEN}) begin
          cnt_nxt           = '0;
          phase_nxt         = PH_HUNT;
          result.frame_done = 1'b1;
        end
      end
      default: begin
        cnt_nxt = '0;
        if (rx_byte == shdl_pkg::SYNC_BYTE) begin
          phase_nxt = PH_CONFIRM;
          ok_nxt    = 1'b1;
        end
      end
    endcase
  end

  // Advance state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cnt_r   <= '0;
      bs_r    <= '0;
      ok_r    <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bs_r    <= bs_nxt;
      ok_r    <= ok_nxt;
    end
  end

  // Confirmation and CRC counts stay inside their fixed lengths
  a_confirm_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CONFIRM |-> cnt_r < shdl_pkg::CONFIRM_LEN)
    else $error("confirm count out of range");

  a_crc_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CRC |-> cnt_r < shdl_pkg::CRC_LEN)
    else $error("crc count out of range");

  // Sync loss always lands back in hunt
  a_serr_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.sync_error |=> phase_r == PH_HUNT)
    else $error("sync error did not return to hunt");

endmodule

// ===== rtl/sync_header_length_deframer_unit.sv =====
// Top level of the sync/header/length deframer.
// Holds the skip registers, the input handshake and the result register.
// Depends on shdl_pkg and shdl_fsm.
//
//   channel  direction  transaction
//   in_      input      one received byte (in_rx_byte)
//   out_     output     one result per byte: payload byte, flags
//   cfg_     input      write of pre/post skip length, no handshake
//
// One byte per cycle: the phase tracker updates in the cycle a byte is taken
// and the result lands in a single output register, seen in the next cycle.
// A new byte is taken while a held result is being read out; out_ready low
// with a result held stalls the input.
// Reset (rst_n low, synchronous) returns to sync hunt with both skips zero.
module sync_header_length_deframer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [shdl_pkg::BYTE_W-1:0]       in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [shdl_pkg::BYTE_W-1:0]       out_payload_byte,
  output logic                              out_payload_valid,
  output logic                              out_payload_last,
  output logic                              out_frame_done,
  output logic                              out_sync_error,
  input  logic                              cfg_we,
  input  logic [shdl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [shdl_pkg::CFG_W-1:0]        cfg_wdata
);

  logic [shdl_pkg::CFG_W-1:0] pre_r, post_r;
  logic                       out_valid_r;
  shdl_pkg::shdl_result_t     res, res_r;
  logic                       in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Hold skip lengths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r  <= '0;
      post_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        shdl_pkg::REG_PRE_SKIP:  pre_r  <= cfg_wdata;
        shdl_pkg::REG_POST_SKIP: post_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  shdl_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_fire),
    .rx_byte   (in_rx_byte),
    .pre_skip  (pre_r),
    .post_skip (post_r),
    .result    (res)
  );

  // Load result on accept, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = res_r.payload_byte;
  assign out_payload_valid = res_r.payload_valid;
  assign out_payload_last  = res_r.payload_last;
  assign out_frame_done    = res_r.frame_done;
  assign out_sync_error    = res_r.sync_error;

  // Every accepted byte yields a held result next cycle
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted byte produced no result");

  // Last marks only a payload byte
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.payload_last |-> res_r.payload_valid)
    else $error("payload_last without payload_valid");

  // Flags belong to distinct phases
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.frame_done && (res_r.payload_valid || res_r.sync_error)))
    else $error("conflicting result flags");

endmodule
